### rtl/dasg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dasg_pkg: shared types and constants of the disk aperture sample generator
// Sizes of the sub-pixel and aperture grids, the aperture cell table, the
// transaction payloads and the operation and register codes.
// ----------------------------------------------------------------------------
package dasg_pkg;

	// Grid and table sizing
	localparam int MAX_RES     = 16;
	localparam int TABLE_DEPTH = 256;
	localparam int PIXEL_BITS  = 12;
	localparam int FRAC_W      = 16;

	localparam int RES_W  = $clog2(MAX_RES + 1);   // holds 1..MAX_RES
	localparam int IDX_W  = $clog2(MAX_RES);       // holds 0..MAX_RES-1
	localparam int TBL_AW = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = TBL_AW + 1;             // holds 0..TABLE_DEPTH
	localparam int TBL_W  = 2 * IDX_W;              // one cell: {i, j}
	localparam int RAST_W = PIXEL_BITS + FRAC_W;

	// Divider lanes: raster x, raster y, aperture u, aperture v
	localparam int DIV_LANES = 4;
	localparam int LANE_RX   = 0;
	localparam int LANE_RY   = 1;
	localparam int LANE_AU   = 2;
	localparam int LANE_AV   = 3;

	// Configuration port
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_PRIMARY_RES   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SECONDARY_RES = 1'b1;

	// Operation codes
	localparam logic OP_START = 1'b0;
	localparam logic OP_EMIT  = 1'b1;

	typedef struct packed {
		logic                  op;
		logic [PIXEL_BITS-1:0] pixel_x;
		logic [PIXEL_BITS-1:0] pixel_y;
	} in_t;

	typedef struct packed {
		logic [RAST_W-1:0] raster_x;
		logic [RAST_W-1:0] raster_y;
		logic [FRAC_W-1:0] aperture_u;
		logic [FRAC_W-1:0] aperture_v;
		logic              last;
	} out_t;

	typedef logic [DIV_LANES-1:0][IDX_W-1:0]  div_num_t;
	typedef logic [DIV_LANES-1:0][RES_W-1:0]  div_den_t;
	typedef logic [DIV_LANES-1:0][FRAC_W-1:0] div_quo_t;

endpackage

### rtl/dasg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dasg_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module dasg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/dasg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dasg_div: four-lane serial divider for cell centre offsets
// Computes floor((2k+1) * 2^(FRAC_W-1) / d) per lane, one quotient bit per
// cycle, all lanes in lockstep. Requires k < d, so the quotient fits FRAC_W.
// ----------------------------------------------------------------------------
module dasg_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  dasg_pkg::div_num_t num,
	input  dasg_pkg::div_den_t den,
	output logic               done,
	output dasg_pkg::div_quo_t quo
);
	import dasg_pkg::*;

	localparam int RW     = IDX_W + 1;
	localparam int STEP_W = $clog2(FRAC_W);

	logic [DIV_LANES-1:0][IDX_W-1:0] rem_q;
	div_quo_t                        quo_q;
	logic [STEP_W-1:0]               step_q;
	logic                            busy_q;
	logic                            done_q;

	logic [DIV_LANES-1:0][RW-1:0]    trial;
	logic [DIV_LANES-1:0]            take;

	// Shift in the next numerator bit: a one on the first step, zeros after
	always_comb begin
		for (int l = 0; l < DIV_LANES; l++) begin
			trial[l] = {rem_q[l], (step_q == '0)};
			take[l]  = trial[l] >= RW'(den[l]);
		end
	end

	// Iterate over the quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_W'(1);
			if (step_q == STEP_W'(FRAC_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Remainder and quotient lanes
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			quo_q <= '0;
		end else if (busy_q) begin
			for (int l = 0; l < DIV_LANES; l++) begin
				if (take[l]) begin
					rem_q[l] <= IDX_W'(trial[l] - RW'(den[l]));
				end else begin
					rem_q[l] <= IDX_W'(trial[l]);
				end
				quo_q[l] <= {quo_q[l][FRAC_W-2:0], take[l]};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

### rtl/disk_aperture_sample_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_aperture_sample_generator_top: stratified pixel / disk aperture sampler
// Emits light-field sample positions for one pixel, sweeping aperture cells
// inside the unit disk, then sub-pixel rows, then sub-pixel columns.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid / in_stall / in_data): op=START latches a pixel and
//     restarts its sequence (no result); op=EMIT produces one result and
//     advances. An item is taken only while the block is idle and no register
//     write is offered.
//   out channel (out_valid / out_stall / out_data): one transaction per EMIT,
//     held in an output register until the receiver lifts out_stall. The next
//     item is accepted while a result still waits; a finished result that
//     cannot be stored stalls the block until the register frees up.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): write the
//     grid sizes; 0 is ignored, values above 16 saturate. Writing the
//     aperture size rebuilds the cell table in memory, with both channels
//     held off.
//   Flow: START latches the pixel and the block stays idle. An EMIT runs
//     through the load state, the 16-step serial divider (one quotient bit per
//     cycle) and the output load; the next item is taken only after its result
//     has been stored in the output register.
//   Reset: grid sizes return to 1 and the one-cell table is rebuilt after
//     reset, during which in_stall and !cfg_ready hold.
// ----------------------------------------------------------------------------
module disk_aperture_sample_generator_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  dasg_pkg::in_t                       in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output dasg_pkg::out_t                      out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dasg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dasg_pkg::CFG_W-1:0]          cfg_data
);
	import dasg_pkg::*;

	localparam int DW   = IDX_W + 1;     // |2i+1-S|
	localparam int SQ_W = 2 * DW + 1;    // sum of two squares

	typedef enum logic [2:0] {
		ST_BUILD,
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [RES_W-1:0]  p_res_q;
	logic [RES_W-1:0]  s_res_q;
	logic [CNT_W-1:0]  ap_count_q;
	logic [TBL_AW-1:0] ap_index_q;
	logic [IDX_W-1:0]  row_q;
	logic [IDX_W-1:0]  col_q;
	logic [PIXEL_BITS-1:0] pix_x_q;
	logic [PIXEL_BITS-1:0] pix_y_q;
	logic [IDX_W-1:0]  bld_i_q;
	logic [IDX_W-1:0]  bld_j_q;
	logic              out_valid_q;
	out_t              out_q;
	logic [IDX_W-1:0]  job_row_q;
	logic [IDX_W-1:0]  job_col_q;
	logic              job_last_q;

	function automatic logic [RES_W-1:0] clamp_res(input logic [CFG_W-1:0] v);
		if (int'(v) > MAX_RES) begin
			return RES_W'(MAX_RES);
		end
		return RES_W'(v);
	endfunction

	// Handshakes
	logic in_fire;
	logic cfg_fire;
	logic out_fire;
	logic slot_free;

	// Hold input off while a register write is offered
	assign in_stall  = (state_q != ST_IDLE) || cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign out_fire  = out_valid_q && !out_stall;
	assign slot_free = !out_valid_q || !out_stall;

	// Disk test for the cell under construction
	logic [DW-1:0]      ctr_i;
	logic [DW-1:0]      ctr_j;
	logic [DW-1:0]      d_i;
	logic [DW-1:0]      d_j;
	logic [SQ_W-1:0]    dist_sq;
	logic [2*RES_W-1:0] rad_sq;
	logic               cell_in;
	logic               bld_last;

	always_comb begin
		ctr_i   = {bld_i_q, 1'b1};
		ctr_j   = {bld_j_q, 1'b1};
		d_i     = (ctr_i >= DW'(s_res_q)) ? ctr_i - DW'(s_res_q) : DW'(s_res_q) - ctr_i;
		d_j     = (ctr_j >= DW'(s_res_q)) ? ctr_j - DW'(s_res_q) : DW'(s_res_q) - ctr_j;
		dist_sq = SQ_W'(d_i) * SQ_W'(d_i) + SQ_W'(d_j) * SQ_W'(d_j);
		rad_sq  = s_res_q * s_res_q;
		cell_in = (dist_sq <= SQ_W'(rad_sq)) && (ap_count_q < CNT_W'(TABLE_DEPTH));
		bld_last = (RES_W'(bld_i_q) == s_res_q - RES_W'(1)) &&
		           (RES_W'(bld_j_q) == s_res_q - RES_W'(1));
	end

	// Cell table memory
	logic              tbl_we;
	logic [TBL_AW-1:0] tbl_raddr;
	logic [TBL_W-1:0]  tbl_rdata;

	assign tbl_we    = (state_q == ST_BUILD) && cell_in;
	assign tbl_raddr = ({1'b0, ap_index_q} < ap_count_q) ? ap_index_q : '0;

	dasg_ram #(
		.WIDTH (TBL_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (ap_count_q[TBL_AW-1:0]),
		.wdata ({bld_i_q, bld_j_q}),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	// Sample position of the accepted item
	logic ap_wrap;
	logic row_wrap;
	logic col_wrap;
	logic is_last;

	assign ap_wrap  = ({1'b0, ap_index_q} + CNT_W'(1)) >= ap_count_q;
	assign row_wrap = (RES_W'(row_q) + RES_W'(1)) >= p_res_q;
	assign col_wrap = (RES_W'(col_q) + RES_W'(1)) >= p_res_q;
	assign is_last  = ap_wrap && row_wrap && col_wrap;

	// Centre offset divider
	div_num_t div_num;
	div_den_t div_den;
	div_quo_t div_quo;
	logic     div_start;
	logic     div_done;

	always_comb begin
		div_num[LANE_RX] = job_col_q;
		div_num[LANE_RY] = job_row_q;
		div_num[LANE_AU] = tbl_rdata[TBL_W-1:IDX_W];
		div_num[LANE_AV] = tbl_rdata[IDX_W-1:0];
		div_den[LANE_RX] = p_res_q;
		div_den[LANE_RY] = p_res_q;
		div_den[LANE_AU] = s_res_q;
		div_den[LANE_AV] = s_res_q;
	end

	assign div_start = (state_q == ST_LOAD);

	dasg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	logic out_load;

	assign out_load = slot_free &&
	                  ((state_q == ST_DONE) || ((state_q == ST_DIV) && div_done));

	// Control: sequencer, grid sizes, counters, latched pixel, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_BUILD;
			p_res_q     <= RES_W'(1);
			s_res_q     <= RES_W'(1);
			ap_count_q  <= '0;
			ap_index_q  <= '0;
			row_q       <= '0;
			col_q       <= '0;
			pix_x_q     <= '0;
			pix_y_q     <= '0;
			bld_i_q     <= '0;
			bld_j_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Output register
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_BUILD: begin
					if (cell_in) begin
						ap_count_q <= ap_count_q + CNT_W'(1);
					end
					if (bld_last) begin
						state_q <= ST_IDLE;
					end else if (RES_W'(bld_j_q) == s_res_q - RES_W'(1)) begin
						bld_j_q <= '0;
						bld_i_q <= bld_i_q + IDX_W'(1);
					end else begin
						bld_j_q <= bld_j_q + IDX_W'(1);
					end
				end
				ST_IDLE: begin
					if (cfg_fire) begin
						// Apply a nonzero write and restart the sequence
						if (cfg_data != '0) begin
							ap_index_q <= '0;
							row_q      <= '0;
							col_q      <= '0;
							if (cfg_index == REG_PRIMARY_RES) begin
								p_res_q <= clamp_res(cfg_data);
							end else begin
								s_res_q    <= clamp_res(cfg_data);
								ap_count_q <= '0;
								bld_i_q    <= '0;
								bld_j_q    <= '0;
								state_q    <= ST_BUILD;
							end
						end
					end else if (in_fire) begin
						if (in_data.op == OP_START) begin
							pix_x_q    <= in_data.pixel_x;
							pix_y_q    <= in_data.pixel_y;
							ap_index_q <= '0;
							row_q      <= '0;
							col_q      <= '0;
						end else begin
							state_q <= ST_LOAD;
							// Advance: aperture fastest, then row, then column
							if (is_last) begin
								ap_index_q <= '0;
								row_q      <= '0;
								col_q      <= '0;
							end else if (!ap_wrap) begin
								ap_index_q <= ap_index_q + TBL_AW'(1);
							end else begin
								ap_index_q <= '0;
								if (!row_wrap) begin
									row_q <= row_q + IDX_W'(1);
								end else begin
									row_q <= '0;
									col_q <= col_q + IDX_W'(1);
								end
							end
						end
					end
				end
				ST_LOAD: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= out_load ? ST_IDLE : ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the sub-pixel position and last flag of the item in flight
	always_ff @(posedge clk) begin
		if (in_fire && (in_data.op == OP_EMIT)) begin
			job_row_q  <= row_q;
			job_col_q  <= col_q;
			job_last_q <= is_last;
		end
	end

	// Assemble the result transaction
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.raster_x   <= {pix_x_q, div_quo[LANE_RX]};
			out_q.raster_y   <= {pix_y_q, div_quo[LANE_RY]};
			out_q.aperture_u <= div_quo[LANE_AU];
			out_q.aperture_v <= div_quo[LANE_AV];
			out_q.last       <= job_last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
